FILE: sv/utf8cs_pkg.sv
// types, constants and helper functions shared by the utf-8 character splitter
package utf8cs_pkg;

  localparam logic [7:0] MaskLead4 = 8'hf8;
  localparam logic [7:0] MaskLead3 = 8'hf0;
  localparam logic [7:0] MaskLead2 = 8'he0;

  localparam logic [7:0] CodeLead4 = 8'hf0;
  localparam logic [7:0] CodeLead3 = 8'he0;
  localparam logic [7:0] CodeLead2 = 8'hc0;

  localparam logic [2:0] LenOne   = 3'd1;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;

  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic        last;
    logic [2:0]  count;
    logic [31:0] bytes;
  } result_t;

  // length class of a byte taken as a lead
  function automatic logic [2:0] lead_class(input logic [7:0] b);
    logic [2:0] len;
    priority if ((b & MaskLead4) == CodeLead4) len = LenFour;
    else if ((b & MaskLead3) == CodeLead3) len = LenThree;
    else if ((b & MaskLead2) == CodeLead2) len = LenTwo;
    else len = LenOne;
    return len;
  endfunction

  // mask covering the lowest n bytes of a 32-bit word
  function automatic logic [31:0] byte_mask(input logic [2:0] n);
    logic [31:0] m;
    unique case (n)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      3'd4:    m = 32'hffff_ffff;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/utf8_character_splitter.sv
// utf-8 character splitter: groups a byte stream into characters by lead class
//
// slave channel s_axis_*: one string byte per item, tlast marks the final byte
// of the string. master channel m_axis_*: one character per item, packed bytes
// and byte count in tdata, tlast on the final character of the string.
// an accepted byte is decoded in the same cycle against the pending bytes and
// the characters it completes (zero to three) are written into a small result
// register; the first one is offered on the next cycle. one byte is taken per
// cycle while each byte yields at most one character and the receiver is ready;
// a string end that flushes an unfinished character yields up to three
// characters, which leave one per cycle, and the input holds off until the last
// of them is being taken. the result register drains into m_axis only, so a
// stalled receiver holds the current character stable and, while a character
// waits on it, stalls the input. reset clears the pending count, the expected
// length and the result count; the block is ready right after reset.
// grouping follows lead bytes only: 11110xxx opens four bytes, 1110xxxx three,
// 110xxxxx two, everything else stands alone; continuation bytes are not
// checked, and an unfinished character at the string end is split again.
module utf8_character_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_string
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] char_bytes, [34:32] byte_count, zero pad
  output logic        m_axis_tlast_o    // last_of_string
);
  import utf8cs_pkg::*;

  logic [7:0]  pend_q [3];
  logic [7:0]  pend_d [3];
  logic [1:0]  cnt_q, cnt_d;
  logic [2:0]  exp_q, exp_d;

  result_t     res_q [MaxResults];
  result_t     res_d [MaxResults];
  logic [1:0]  rem_q, rem_d;

  logic        in_acc, out_acc;
  logic [7:0]  b;
  logic [31:0] pend_w, buf_w;
  logic [2:0]  n;

  result_t     new_res [MaxResults];
  logic [1:0]  new_k;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (rem_q == 2'd0) || ((rem_q == 2'd1) && m_axis_tready_i);

  assign m_axis_tvalid_o = (rem_q != 2'd0);
  assign m_axis_tdata_o  = {5'd0, res_q[0].count, res_q[0].bytes};
  assign m_axis_tlast_o  = res_q[0].last;

  assign b      = s_axis_tdata_i;
  assign pend_w = {8'h00, pend_q[2], pend_q[1], pend_q[0]};
  assign buf_w  = (pend_w & byte_mask({1'b0, cnt_q})) | ({24'h0, b} << {cnt_q, 3'b000});
  assign n      = {1'b0, cnt_q} + 3'd1;

  // decode of one byte against the pending character
  always_comb begin
    logic [2:0]  pos;
    logic [2:0]  len;
    logic [31:0] sh;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    exp_d  = exp_q;
    new_k  = 2'd0;
    pos    = 3'd0;
    len    = LenOne;
    sh     = 32'h0;
    for (int s = 0; s < MaxResults; s++) begin
      new_res[s] = '0;
    end
    if (s_axis_tlast_i) begin
      // flush: walk the buffered bytes, a group only forms if it fits
      for (int s = 0; s < MaxResults; s++) begin
        if (pos < n) begin
          sh  = buf_w >> {pos, 3'b000};
          len = lead_class(sh[7:0]);
          if (({1'b0, pos} + {1'b0, len}) > {1'b0, n}) len = LenOne;
          new_res[s].bytes = sh & byte_mask(len);
          new_res[s].count = len;
          pos   = pos + len;
          new_k = new_k + 2'd1;
        end
      end
      for (int s = 0; s < MaxResults; s++) begin
        if (2'(s) == (new_k - 2'd1)) new_res[s].last = 1'b1;
      end
      cnt_d = 2'd0;
      exp_d = 3'd0;
    end else if (cnt_q == 2'd0) begin
      len = lead_class(b);
      if (len == LenOne) begin
        new_res[0].bytes = {24'h0, b};
        new_res[0].count = LenOne;
        new_k = 2'd1;
      end else begin
        pend_d[0] = b;
        cnt_d     = 2'd1;
        exp_d     = len;
      end
    end else if (n >= exp_q) begin
      new_res[0].bytes = buf_w & byte_mask(n);
      new_res[0].count = n;
      new_k = 2'd1;
      cnt_d = 2'd0;
      exp_d = 3'd0;
    end else begin
      if (cnt_q != 2'd3) pend_d[cnt_q] = b;
      cnt_d = n[1:0];
    end
  end

  // result register: loaded on accept, shifted down as characters leave
  always_comb begin
    res_d = res_q;
    rem_d = rem_q;
    if (in_acc) begin
      res_d = new_res;
      rem_d = new_k;
    end else if (out_acc) begin
      res_d[0] = res_q[1];
      res_d[1] = res_q[2];
      rem_d    = rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      exp_q <= 3'd0;
      rem_q <= 2'd0;
    end else begin
      if (in_acc) begin
        cnt_q <= cnt_d;
        exp_q <= exp_d;
      end
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) pend_q <= pend_d;
    res_q <= res_d;
  end

  // a string end always leaves the splitter with nothing pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> (cnt_q == 2'd0 && exp_q == 3'd0))
    else $error("pending state not cleared after string end");

  // the pending part is always shorter than the character it belongs to
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> ({1'b0, cnt_q} < exp_q && exp_q <= LenFour))
    else $error("pending count out of step with expected length");

  // every character offered carries one to four bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res_q[0].count != 3'd0 && res_q[0].count <= LenFour))
    else $error("character with bad byte count");

  // a string-end item always produces at least one character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> (rem_q != 2'd0))
    else $error("string end produced no character");

endmodule

FILE: tb/utf8_character_splitter_tb.sv
// testbench for the utf-8 character splitter: directed and random strings, checked item by item
module utf8_character_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8cs_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned RandItemsPerPhase = 105;

  typedef enum logic [1:0] {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = 8'h00;
  logic        s_last = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_data;
  logic        m_last;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;

  // predictor state: bytes of the unfinished character, first byte lowest
  logic [23:0] open_word = '0;
  int unsigned open_cnt = 0;
  int unsigned open_len = 0;
  result_t     expected_chars[$];

  utf8_character_splitter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned char_length(input logic [7:0] b);
    if ((b & MaskLead4) == CodeLead4) return int'(LenFour);
    if ((b & MaskLead3) == CodeLead3) return int'(LenThree);
    if ((b & MaskLead2) == CodeLead2) return int'(LenTwo);
    return int'(LenOne);
  endfunction

  function automatic result_t make_char(input logic [31:0] word, input int unsigned first,
                                        input int unsigned len, input logic last);
    result_t r;
    r.bytes = '0;
    for (int unsigned j = 0; j < len; j++) r.bytes[8*j +: 8] = word[8*(first+j) +: 8];
    r.count = 3'(len);
    r.last  = last;
    return r;
  endfunction

  // works out the characters that one accepted byte completes
  function automatic void predict_chars(input logic [7:0] b, input logic eos);
    logic [31:0] word;
    int unsigned n;
    int unsigned i;
    int unsigned len;
    word = {8'h00, open_word};
    word[8*open_cnt +: 8] = b;
    n = open_cnt + 1;
    if (eos) begin
      // flush: split what is buffered again, a group only where it fits
      i = 0;
      while (i < n) begin
        len = char_length(word[8*i +: 8]);
        if (i + len > n) len = 1;
        expected_chars.insert(expected_chars.size(), make_char(word, i, len, (i + len) == n));
        i += len;
      end
      open_cnt = 0;
      open_len = 0;
    end else if (open_cnt == 0) begin
      len = char_length(b);
      if (len == 1) begin
        expected_chars.insert(expected_chars.size(), make_char(word, 0, 1, 1'b0));
      end else begin
        open_word[7:0] = b;
        open_cnt = 1;
        open_len = len;
      end
    end else if (n >= open_len) begin
      expected_chars.insert(expected_chars.size(), make_char(word, 0, n, 1'b0));
      open_cnt = 0;
      open_len = 0;
    end else begin
      open_word[8*open_cnt +: 8] = b;
      open_cnt = n;
    end
  endfunction

  // accepted items on both sides, checking and watchdog
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (s_valid && s_ready) predict_chars(s_data, s_last);
      if (m_valid && m_ready) begin
        got.bytes = m_data[31:0];
        got.count = m_data[34:32];
        got.last  = m_last;
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected item bytes %h count %0d last %0b",
                   $time, got.bytes, got.count, got.last);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (got.bytes !== want.bytes) begin
            $display("%0t: char_bytes expected %h got %h", $time, want.bytes, got.bytes);
            errors++;
          end
          if (got.count !== want.count) begin
            $display("%0t: byte_count expected %0d got %0d", $time, want.count, got.count);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last_of_string expected %0b got %0b", $time, want.last, got.last);
            errors++;
          end
        end
      end
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
          $display("[utf8_character_splitter] ERROR");
          $finish;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) m_ready <= 1'b0;
    else m_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic set_idle(input idle_mode_e mode);
    send_idle_pct  = (mode == IdleSender)   ? 69 : (mode == IdleBoth) ? 15 : 0;
    recv_stall_pct = (mode == IdleReceiver) ? 69 : (mode == IdleBoth) ? 15 : 0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= eos;
    do @(posedge clk_i); while (!s_ready);
  endtask

  // sender holds off until every expected character has come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);  // zero byte does not end the string
    send_byte(8'h7f, 1'b0);
    send_byte(8'h80, 1'b0);  // stray continuation
    send_byte(8'hff, 1'b0);
    send_byte(8'hf8, 1'b0);
  endtask

  task automatic test_multi_byte();
    send_byte(8'hc3, 1'b0);
    send_byte(8'ha9, 1'b0);
    send_byte(8'he2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hac, 1'b0);
    send_byte(8'hf0, 1'b0);
    send_byte(8'h9f, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    // continuations taken whatever their value
    send_byte(8'he2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hff, 1'b0);
  endtask

  task automatic test_string_end();
    send_byte(8'hc3, 1'b1);  // lead as final byte
    send_byte(8'hf0, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hc3, 1'b1);
    // inner three-byte lead does not fit in what remains
    send_byte(8'hf0, 1'b0);
    send_byte(8'he2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hf0, 1'b0);
    send_byte(8'h9f, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  // mostly well-formed characters with random payload, some noise and cut-off strings
  task automatic test_random_strings(input idle_mode_e mode, input int unsigned n_items);
    logic [7:0]  str_q[$];
    int unsigned sent;
    int unsigned n_chars;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  r;
    set_idle(mode);
    sent = 0;
    while (sent < n_items) begin
      str_q.delete();
      n_chars = $urandom_range(8, 1);
      for (int unsigned c = 0; c < n_chars; c++) begin
        r = 8'($urandom_range(255));
        if ($urandom_range(99) < 75) begin
          len = $urandom_range(4, 1);
          case (len)
            1: str_q.insert(str_q.size(), {1'b0, r[6:0]});
            2: str_q.insert(str_q.size(), {3'b110, r[4:0]});
            3: str_q.insert(str_q.size(), {4'b1110, r[3:0]});
            default: str_q.insert(str_q.size(), {5'b11110, r[2:0]});
          endcase
          for (int unsigned j = 1; j < len; j++)
            str_q.insert(str_q.size(), {2'b10, 6'($urandom_range(63))});
        end else begin
          str_q.insert(str_q.size(), r);
        end
      end
      if (str_q.size() > 1 && $urandom_range(3) == 0) begin
        cut = $urandom_range(3, 1);
        while (cut > 0 && str_q.size() > 1) begin
          void'(str_q.pop_back());
          cut--;
        end
      end
      foreach (str_q[i]) begin
        send_byte(str_q[i], i == str_q.size() - 1);
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_idle(IdleNone);
    test_single_bytes();
    test_multi_byte();
    test_string_end();
    wait_drained();

    test_random_strings(IdleNone, RandItemsPerPhase);
    test_random_strings(IdleSender, RandItemsPerPhase);
    test_random_strings(IdleReceiver, RandItemsPerPhase);
    test_random_strings(IdleBoth, RandItemsPerPhase);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("[utf8_character_splitter] OK");
    end else begin
      $display("[utf8_character_splitter] ERROR");
    end
    $finish;
  end

endmodule

FILE: utf8_character_splitter.f
sv/utf8cs_pkg.sv
sv/utf8_character_splitter.sv
tb/utf8_character_splitter_tb.sv
